@@ hdl/integer_to_base_n_text_top_macros.svh @@
// Assertion macros shared by the integer to text converter.
`ifndef INTEGER_TO_BASE_N_TEXT_TOP_MACROS_SVH
`define INTEGER_TO_BASE_N_TEXT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITOB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integer_to_base_n_text: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ITOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integer_to_base_n_text: next-cycle check failed");

`endif

@@ hdl/itob_pkg.sv @@
// Package with widths, ASCII constants and helper functions of the converter.
`default_nettype none
package itob_pkg;

	localparam int VALUE_W      = 64;
	localparam int MAG_W        = 63;
	localparam int RADIX_W      = 6;
	localparam int DIGIT_W      = 6;
	localparam int CHAR_W       = 7;
	localparam int DIV_STEPS    = 63;
	localparam int STEP_W       = 6;
	localparam int MAX_DIGITS_D = 64;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

	// Bases outside 2..36 saturate to the nearest end of the range.
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN)
			return RADIX_MIN;
		else if (r > RADIX_MAX)
			return RADIX_MAX;
		else
			return r;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		if (d < 6'd10)
			return CH_ZERO + {1'b0, d};
		else
			return CH_A + {1'b0, d} - 7'd10;
	endfunction

endpackage
`default_nettype wire

@@ hdl/itob_if.sv @@
// Handshake channel interfaces for the value, text and radix channels.
`default_nettype none
interface itob_value_if import itob_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itob_text_if import itob_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;
	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface itob_cfg_if import itob_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RADIX_W-1:0] radix;
	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface
`default_nettype wire

@@ hdl/integer_to_base_n_text_top.sv @@
// Signed 64-bit integer to ASCII text converter in a configurable base.
`default_nettype none
`include "integer_to_base_n_text_top_macros.svh"

// Each request on the item channel carries one signed 64-bit value. The block
// turns it into text in the base held in the radix register (2 to 36, reset 10;
// values outside that range saturate) and sends one request per character on
// the text channel, most significant digit first, using '0'-'9' and 'A'-'Z'.
// A negative value is preceded by '-', zero gives "0", and the final character
// of a number has last set. The most negative value is treated as one above it.
// Digits come from a single bit-serial restoring divider that is reused for
// every digit. Then each character is a registered read of the digit store
// (fetch state) followed by the load of the output register (emit state,
// which waits until that register is free); a negative number first loads
// its sign. The item channel is ready only while the block is idle; the last
// character may still wait in the output register when the next value is
// taken. The radix channel is always ready and must only be written while
// the block is idle. If MAX_DIGITS is below the digit count, only the least
// significant MAX_DIGITS digits are kept and sent.
module integer_to_base_n_text_top
	import itob_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_D
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	itob_cfg_if.sink    cfg,
	itob_value_if.sink  item,
	itob_text_if.source text
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_SIGN  = 5'b00100,
		ST_FETCH = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_q;
	logic [MAG_W-1:0]   quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   digit_cnt_q;
	logic               neg_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

	// Input side: load the magnitude and clamp the most negative value.
	logic                item_acc;
	logic [VALUE_W-1:0]  val_clamped;
	logic [VALUE_W-1:0]  val_neg;
	logic [MAG_W-1:0]    mag;

	// Shared divider: one restoring step per cycle.
	logic [DIGIT_W:0]   partial;
	logic               q_bit;
	logic [DIGIT_W-1:0] rem_next;
	logic [MAG_W-1:0]   quo_next;
	logic               last_step;
	logic               store_ok;
	logic               mem_we;
	logic [CNT_W-1:0]   cnt_next;

	logic out_free;
	logic out_load;
	logic [CHAR_W-1:0] load_char;
	logic              load_last;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;

	assign val_clamped = (item.value == {1'b1, {(VALUE_W-1){1'b0}}}) ?
		{1'b1, {(VALUE_W-2){1'b0}}, 1'b1} : item.value;
	assign val_neg = -val_clamped;
	assign mag     = val_clamped[VALUE_W-1] ? val_neg[MAG_W-1:0] : val_clamped[MAG_W-1:0];

	assign partial   = {rem_q, quo_q[MAG_W-1]};
	assign q_bit     = (partial >= {1'b0, base_q});
	assign rem_next  = q_bit ? DIGIT_W'(partial - {1'b0, base_q}) : partial[DIGIT_W-1:0];
	assign quo_next  = {quo_q[MAG_W-2:0], q_bit};
	assign last_step = (state_q == ST_DIV) && (step_q == STEP_W'(DIV_STEPS - 1));
	assign store_ok  = (digit_cnt_q < CNT_W'(MAX_DIGITS));
	assign mem_we    = last_step && store_ok;
	assign cnt_next  = store_ok ? digit_cnt_q + CNT_W'(1) : digit_cnt_q;

	// The output register is free when empty or when its request is taken.
	assign out_free = !out_valid_q || text.ready;

	always_comb begin
		out_load  = 1'b0;
		load_char = CH_MINUS;
		load_last = 1'b0;
		unique case (state_q)
			ST_SIGN: begin
				out_load = out_free;
			end
			ST_EMIT: begin
				out_load  = out_free;
				load_char = digit_char(rd_data_q);
				load_last = (rd_idx_q == '0);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg.valid && cfg.ready) begin
			radix_q <= cfg.radix;
		end
	end

	// Sequencer: divide until the quotient is zero, then send the text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= RADIX_RESET;
			quo_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			digit_cnt_q <= '0;
			neg_q       <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						base_q      <= eff_radix(radix_q);
						quo_q       <= mag;
						neg_q       <= val_clamped[VALUE_W-1];
						rem_q       <= '0;
						step_q      <= '0;
						digit_cnt_q <= '0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_next;
					if (last_step) begin
						rem_q       <= '0;
						step_q      <= '0;
						digit_cnt_q <= cnt_next;
						if (quo_next == '0) begin
							rd_idx_q <= IDX_W'(cnt_next - CNT_W'(1));
							state_q  <= neg_q ? ST_SIGN : ST_FETCH;
						end
					end else begin
						rem_q  <= rem_next;
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SIGN: begin
					if (out_load) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (load_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - IDX_W'(1);
							state_q  <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_store[digit_cnt_q[IDX_W-1:0]] <= rem_next;
		end
		rd_data_q <= digit_store[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

	`ITOB_ASSERT_NOW(a_step_range, clk, arst_n, state_q == ST_DIV, step_q < STEP_W'(DIV_STEPS))
	`ITOB_ASSERT_NOW(a_rem_below_base, clk, arst_n, state_q == ST_DIV, rem_q < base_q)
	`ITOB_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, digit_cnt_q <= CNT_W'(MAX_DIGITS))
	`ITOB_ASSERT_NEXT(a_accept_starts, clk, arst_n, item_acc,
		state_q == ST_DIV && digit_cnt_q == '0)

endmodule
`default_nettype wire

@@ test/itob_text_checker.sv @@
// Checker that predicts the text of each accepted value and compares it with the text channel.
`timescale 1ns / 1ps
`default_nettype none
module itob_text_checker
	import itob_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_D
) (
	input  wire logic clk,
	input  wire logic arst_n,
	itob_cfg_if       cfg,
	itob_value_if     item,
	itob_text_if      text,
	output int        mismatch_count,
	output int        pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_beat_t;

	logic [RADIX_W-1:0] radix_reg;
	text_beat_t         chars_due[$];

	// Appends the characters that one value should produce in the current base.
	function automatic void spell_value(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] v;
		logic [MAG_W-1:0]   q;
		logic [RADIX_W-1:0] base;
		logic [DIGIT_W-1:0] digits[MAX_DIGITS];
		logic [CHAR_W-1:0]  ch;
		int                 n;
		v = raw;
		if (v == 64'h8000_0000_0000_0000) begin
			v = 64'h8000_0000_0000_0001;
		end
		if (radix_reg < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_reg > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_reg;
		end
		if (v[VALUE_W-1]) begin
			chars_due.push_back('{character: CH_MINUS, last: 1'b0});
			v = -v;
		end
		q = v[MAG_W-1:0];
		n = 0;
		do begin
			if (n < MAX_DIGITS) begin
				digits[n] = DIGIT_W'(q % base);
				n++;
			end
			q = q / base;
		end while (q != 0);
		for (int i = n - 1; i >= 0; i--) begin
			if (digits[i] < 10) begin
				ch = CH_ZERO + CHAR_W'(digits[i]);
			end else begin
				ch = CH_A + CHAR_W'(digits[i]) - 7'd10;
			end
			chars_due.push_back('{character: ch, last: (i == 0)});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		text_beat_t due;
		int         bad;
		if (!arst_n) begin
			radix_reg      <= RADIX_RESET;
			chars_due.delete();
			pending        <= 0;
			mismatch_count <= 0;
		end else begin
			bad = 0;
			if (text.valid && text.ready) begin
				if (chars_due.size() == 0) begin
					$error("character %02h arrived with no request pending", text.character);
					bad++;
				end else begin
					due = chars_due.pop_front();
					if (text.character !== due.character) begin
						$error("character: expected %02h, got %02h", due.character,
							text.character);
						bad++;
					end
					if (text.last !== due.last) begin
						$error("last: expected %0b, got %0b", due.last, text.last);
						bad++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				radix_reg <= cfg.radix;
			end
			if (item.valid && item.ready) begin
				spell_value(item.value);
			end
			pending        <= chars_due.size();
			mismatch_count <= mismatch_count + bad;
		end
	end

endmodule
`default_nettype wire

@@ test/tb_integer_to_base_n_text_top.sv @@
// Testbench top: drives values and radix writes into the converter and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_integer_to_base_n_text_top;
	import itob_pkg::*;

	// The block is built with the full digit store, so every 63-bit magnitude fits.
	localparam int TEXT_DIGITS = MAX_DIGITS_D;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

	// Length of the one long receiver hold-off; longer than a full base 2 conversion,
	// so the block parks a character in its output, stalls and refuses further requests.
	localparam int LONG_HOLD = 6000;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   pending;
	int   burst_left;
	bit   hold_text;

	itob_cfg_if   cfg_ch ();
	itob_value_if item_ch ();
	itob_text_if  text_ch ();

	always #5 clk = ~clk;

	integer_to_base_n_text_top #(
		.MAX_DIGITS(TEXT_DIGITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.item  (item_ch),
		.text  (text_ch)
	);

	// The checker sees every handshake, keeps its own copy of the radix and
	// reports how many characters are still owed and how many checks failed.
	itob_text_checker #(
		.MAX_DIGITS(TEXT_DIGITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.item          (item_ch),
		.text          (text_ch),
		.mismatch_count(mismatch_count),
		.pending       (pending)
	);

	// Offers one value and returns at the edge where it is accepted. Requests go out
	// in bursts; when a burst runs out, valid drops and stays low through a random
	// pause before the next burst starts, so valid is never lowered and raised in
	// the same step. Within a burst valid simply stays high and the value changes.
	task automatic offer_value(input logic signed [VALUE_W-1:0] v);
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 5);
		end
		item_ch.valid <= 1'b1;
		item_ch.value <= v;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		burst_left--;
	endtask

	// The radix may only change while the block is idle, so the write waits
	// until every owed character has been seen, then lets a short pause pass.
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.radix <= r;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random values of several shapes: fully random words, magnitudes of a
	// random bit length (so digit counts spread evenly), small numbers near
	// zero, and the extremes including the most negative value.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] raw;
		int                 len;
		raw = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
			end
			4, 5, 6: begin
				len = $urandom_range(1, 63);
				raw = raw & ((64'd1 << len) - 64'd1);
				if ($urandom_range(0, 1) == 1) begin
					raw = -raw;
				end
			end
			7: begin
				raw = 64'($urandom_range(0, 2000));
				if ($urandom_range(0, 1) == 1) begin
					raw = -raw;
				end
			end
			default: begin
				case ($urandom_range(0, 3))
					0: raw = VALUE_MAX;
					1: raw = -VALUE_MAX;
					2: raw = VALUE_MIN;
					default: raw = '0;
				endcase
			end
		endcase
		return raw;
	endfunction

	task automatic run_phase(input logic [RADIX_W-1:0] r, input int count);
		write_radix(r);
		repeat (count) offer_value(pick_value());
	endtask

	// Receiver: ready follows a pattern that is redrawn at random intervals
	// (always ready, mostly ready, mostly stalled, alternating), so stalls land
	// on the sign, the middle digits and the final character alike. Once the
	// stimulus asks for it, ready is held low for a long stretch.
	initial begin : text_sink
		int mode;
		int stretch;
		bit toggle;
		bit hold_done;
		text_ch.ready <= 1'b0;
		toggle    = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(8, 64);
			repeat (stretch) begin
				@(posedge clk);
				if (hold_text && !hold_done) begin
					hold_done = 1'b1;
					text_ch.ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				toggle = ~toggle;
				case (mode)
					0: text_ch.ready <= 1'b1;
					1: text_ch.ready <= ($urandom_range(0, 3) != 0);
					2: text_ch.ready <= ($urandom_range(0, 3) == 0);
					default: text_ch.ready <= toggle;
				endcase
			end
		end
	end

	initial begin : stimulus
		arst_n        <= 1'b0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.radix  <= '0;
		item_ch.valid <= 1'b0;
		item_ch.value <= '0;
		hold_text  = 1'b0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part in the reset base of ten: zero, small values of both
		// signs, the largest magnitudes and the most negative value.
		offer_value(0);
		offer_value(1);
		offer_value(-1);
		offer_value(9);
		offer_value(10);
		offer_value(-10);
		offer_value(VALUE_MAX);
		offer_value(-VALUE_MAX);
		offer_value(VALUE_MIN);

		// Base two gives the longest text, 63 digits plus the sign.
		write_radix(6'd2);
		offer_value(0);
		offer_value(VALUE_MAX);
		offer_value(-1);
		offer_value(VALUE_MIN);

		// Base thirty-six reaches the letter Z and the digit wrap at 36.
		write_radix(6'd36);
		offer_value(35);
		offer_value(36);
		offer_value(-35);
		offer_value(VALUE_MAX);
		offer_value(VALUE_MIN);

		// Out-of-range bases saturate: zero and one act as two, 63 as 36.
		write_radix(6'd0);
		offer_value(5);
		write_radix(6'd63);
		offer_value(35);
		write_radix(6'd1);
		offer_value(-2);

		// Random part across several bases. The long receiver hold-off starts
		// with the third phase, once its radix is written, while the sender
		// keeps offering values.
		run_phase(6'd16, 12);
		run_phase(6'd8, 12);
		write_radix(6'd10);
		hold_text = 1'b1;
		repeat (12) offer_value(pick_value());
		run_phase(6'd2, 12);
		run_phase(6'd36, 12);
		run_phase(6'd37, 12);
		run_phase(6'd3, 12);
		run_phase(6'd0, 12);
		repeat (2) run_phase(RADIX_W'($urandom_range(0, 63)), 12);

		// Drain: wait for every owed character, then watch a while for strays.
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("integer_to_base_n_text_top regression: pass");
		end else begin
			$display("integer_to_base_n_text_top regression: fail");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run, all values in base two
	// with every character stalled and the long hold-off included.
	initial begin : watchdog
		#40ms;
		$display("integer_to_base_n_text_top regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
